@@ rtl/msa_pkg.sv @@
// Shared constants, types and register codes for the moving average range scaler.
package msa_pkg;

  // AVG_DEPTH must be a power of two: the mean is taken with a shift.
  localparam int AVG_DEPTH   = 8;
  localparam int SAMPLE_BITS = 12;
  localparam int AVG_LOG2    = $clog2(AVG_DEPTH);
  localparam int SLOT_BITS   = AVG_LOG2;
  localparam int SUM_BITS    = SAMPLE_BITS + AVG_LOG2;

  localparam int SAMPLE_W    = 12;
  localparam int TIME_W      = 32;
  localparam int AVG_BITS    = 12;
  localparam int SCALED_BITS = 16;
  localparam int SPAN_BITS   = 12;
  localparam int PROD_BITS   = SPAN_BITS + SCALED_BITS;
  localparam int DIV_CNT_BITS = $clog2(PROD_BITS);

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SPAN_LOW   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPAN_HIGH  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FULL_RANGE = 2'd2;

  localparam logic [SPAN_BITS-1:0]   SPAN_LOW_RST   = 12'd0;
  localparam logic [SPAN_BITS-1:0]   SPAN_HIGH_RST  = 12'd4095;
  localparam logic [SCALED_BITS-1:0] FULL_RANGE_RST = 16'd1000;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [AVG_BITS-1:0] average;
    logic [TIME_W-1:0]   stamp_ms;
  } item_t;

  typedef struct packed {
    logic [SPAN_BITS-1:0]   span_low;
    logic [SPAN_BITS-1:0]   span_high;
    logic [SCALED_BITS-1:0] full_range;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ rtl/msa_in_if.sv @@
// Sample request channel: valid, ready, sample and time stamp.
interface msa_in_if;
  logic                         valid;
  logic                         ready;
  logic [msa_pkg::SAMPLE_W-1:0] sample;
  logic [msa_pkg::TIME_W-1:0]   time_ms;

  modport source(output valid, output sample, output time_ms, input ready);
  modport sink(input valid, input sample, input time_ms, output ready);
endinterface

@@ rtl/msa_out_if.sv @@
// Result request channel: valid, ready, average, scaled value and time stamp.
interface msa_out_if;
  logic                            valid;
  logic                            ready;
  logic [msa_pkg::AVG_BITS-1:0]    average;
  logic [msa_pkg::SCALED_BITS-1:0] scaled;
  logic [msa_pkg::TIME_W-1:0]      stamp_ms;

  modport source(output valid, output average, output scaled, output stamp_ms, input ready);
  modport sink(input valid, input average, input scaled, input stamp_ms, output ready);
endinterface

@@ rtl/msa_cfg_if.sv @@
// Configuration write channel: valid, ready, register index and write data.
interface msa_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [msa_pkg::CFG_INDEX_BITS-1:0] index;
  logic [msa_pkg::CFG_DATA_BITS-1:0]  data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/msa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module msa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ rtl/msa_front.sv @@
// Front end: takes samples, updates the sample ring and running sum, queues the mean.
module msa_front (
  input  logic              clk,
  input  logic              rst_n,
  msa_in_if.sink            in_ch,
  input  msa_pkg::q_stat_t  q_stat,
  output logic              push,
  output msa_pkg::item_t    push_item
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_LOAD = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t state_r, state_nxt;

  logic [msa_pkg::SUM_BITS-1:0]    sum_r;
  logic [msa_pkg::SLOT_BITS-1:0]   slot_r;
  logic                            primed_r;
  logic                            wrapped_r;
  logic [msa_pkg::SAMPLE_BITS-1:0] prime_r;
  logic [msa_pkg::SAMPLE_BITS-1:0] sample_r;
  logic [msa_pkg::TIME_W-1:0]      stamp_r;

  logic                            accept;
  logic                            ram_we;
  logic [msa_pkg::SAMPLE_BITS-1:0] ram_rdata;
  logic [msa_pkg::SAMPLE_BITS-1:0] old_sample;
  logic [msa_pkg::SUM_BITS-1:0]    rounded;

  assign in_ch.ready = (state_r == F_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign ram_we      = (state_r == F_LOAD) && primed_r;
  assign old_sample  = wrapped_r ? ram_rdata : prime_r;

  msa_ram #(
    .WIDTH(msa_pkg::SAMPLE_BITS),
    .DEPTH(msa_pkg::AVG_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_r),
    .wdata(sample_r),
    .raddr(slot_r),
    .rdata(ram_rdata)
  );

  assign rounded            = sum_r + msa_pkg::SUM_BITS'(msa_pkg::AVG_DEPTH / 2);
  assign push_item.average  = msa_pkg::AVG_BITS'(rounded >> msa_pkg::AVG_LOG2);
  assign push_item.stamp_ms = stamp_r;
  assign push               = (state_r == F_PUSH) && !q_stat.full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_LOAD;
        end
      end
      F_LOAD: state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_stat.full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      sum_r     <= '0;
      slot_r    <= '0;
      primed_r  <= 1'b0;
      wrapped_r <= 1'b0;
      prime_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_LOAD) begin
        if (!primed_r) begin
          primed_r <= 1'b1;
          prime_r  <= sample_r;
          sum_r    <= msa_pkg::SUM_BITS'(sample_r) << msa_pkg::AVG_LOG2;
        end else begin
          sum_r <= sum_r - msa_pkg::SUM_BITS'(old_sample) + msa_pkg::SUM_BITS'(sample_r);
          if (slot_r == msa_pkg::SLOT_BITS'(msa_pkg::AVG_DEPTH - 1)) begin
            slot_r    <= '0;
            wrapped_r <= 1'b1;
          end else begin
            slot_r <= slot_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= msa_pkg::SAMPLE_BITS'(in_ch.sample);
      stamp_r  <= in_ch.time_ms;
    end
  end

endmodule

@@ rtl/msa_fifo.sv @@
// Short queue of averaged requests between the front end and the scaler.
module msa_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  msa_pkg::item_t   push_item,
  input  logic             pop,
  output msa_pkg::item_t   pop_item,
  output msa_pkg::q_stat_t stat
);

  msa_pkg::item_t                mem_r [msa_pkg::QUEUE_DEPTH];
  logic [msa_pkg::QPTR_BITS-1:0] wptr_r;
  logic [msa_pkg::QPTR_BITS-1:0] rptr_r;
  logic [msa_pkg::QCNT_BITS-1:0] count_r;
  logic                          do_push;
  logic                          do_pop;

  assign stat.full  = (count_r == msa_pkg::QCNT_BITS'(msa_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_item   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == msa_pkg::QPTR_BITS'(msa_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == msa_pkg::QPTR_BITS'(msa_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

endmodule

@@ rtl/msa_scale.sv @@
// Back end: maps each mean onto 0..full_range with a bit-serial divider, holds the result.
module msa_scale (
  input  logic             clk,
  input  logic             rst_n,
  input  msa_pkg::cfg_t    cfg,
  input  msa_pkg::q_stat_t q_stat,
  output logic             pop,
  input  msa_pkg::item_t   pop_item,
  msa_out_if.source        out_ch
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_DIV  = 4'b0100,
    B_DONE = 4'b1000
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [msa_pkg::AVG_BITS-1:0]     avg_r;
  logic [msa_pkg::TIME_W-1:0]       stamp_r;
  logic [msa_pkg::PROD_BITS-1:0]    num_r;
  logic [msa_pkg::SPAN_BITS:0]      rem_r;
  logic [msa_pkg::SPAN_BITS-1:0]    div_r;
  logic [msa_pkg::DIV_CNT_BITS-1:0] cnt_r;
  logic [msa_pkg::SCALED_BITS-1:0]  value_r;
  logic                             out_valid_r;
  logic [msa_pkg::AVG_BITS-1:0]     out_avg_r;
  logic [msa_pkg::SCALED_BITS-1:0]  out_scaled_r;
  logic [msa_pkg::TIME_W-1:0]       out_stamp_r;

  logic [msa_pkg::SPAN_BITS-1:0]    lo;
  logic [msa_pkg::SPAN_BITS-1:0]    hi;
  logic                             invert;
  logic [msa_pkg::SPAN_BITS-1:0]    offset;
  logic [msa_pkg::SPAN_BITS:0]      rem_shift;
  logic                             qbit;
  logic [msa_pkg::SPAN_BITS:0]      rem_next;
  logic [msa_pkg::PROD_BITS-1:0]    num_next;
  logic                             out_free;
  logic                             last_step;

  assign lo     = (cfg.span_low < cfg.span_high) ? cfg.span_low : cfg.span_high;
  assign hi     = (cfg.span_low < cfg.span_high) ? cfg.span_high : cfg.span_low;
  assign invert = cfg.span_high < cfg.span_low;
  assign offset = msa_pkg::SPAN_BITS'(avg_r) - lo;

  // restoring division, one quotient bit per cycle, quotient shifts into num_r
  assign rem_shift = {rem_r[msa_pkg::SPAN_BITS-1:0], num_r[msa_pkg::PROD_BITS-1]};
  assign qbit      = rem_shift >= {1'b0, div_r};
  assign rem_next  = qbit ? rem_shift - {1'b0, div_r} : rem_shift;
  assign num_next  = {num_r[msa_pkg::PROD_BITS-2:0], qbit};
  assign last_step = (cnt_r == msa_pkg::DIV_CNT_BITS'(msa_pkg::PROD_BITS - 1));

  assign out_free = !out_valid_r || out_ch.ready;
  assign pop      = (state_r == B_IDLE) && !q_stat.empty;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.average  = out_avg_r;
  assign out_ch.scaled   = out_scaled_r;
  assign out_ch.stamp_ms = out_stamp_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        if (msa_pkg::SPAN_BITS'(avg_r) <= lo || msa_pkg::SPAN_BITS'(avg_r) >= hi) begin
          state_nxt = B_DONE;
        end else begin
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        if (last_step) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == B_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        avg_r   <= pop_item.average;
        stamp_r <= pop_item.stamp_ms;
      end
      B_MUL: begin
        cnt_r <= '0;
        rem_r <= '0;
        div_r <= hi - lo;
        num_r <= msa_pkg::PROD_BITS'(offset) * msa_pkg::PROD_BITS'(cfg.full_range);
        if (msa_pkg::SPAN_BITS'(avg_r) <= lo) begin
          value_r <= '0;
        end else begin
          value_r <= cfg.full_range;
        end
      end
      B_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        rem_r <= rem_next;
        num_r <= num_next;
        if (last_step) begin
          value_r <= msa_pkg::SCALED_BITS'(num_next);
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_avg_r    <= avg_r;
          out_stamp_r  <= stamp_r;
          out_scaled_r <= invert ? cfg.full_range - value_r : value_r;
        end
      end
      default: begin
        cnt_r <= '0;
      end
    endcase
  end

endmodule

@@ rtl/moving_average_range_scaler_core.sv @@
// Top level of the moving average range scaler: config registers, front end, queue, scaler.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        sample[11:0], time_ms[31:0]
//   out_ch   out  valid/ready        average[11:0], scaled[15:0], stamp_ms[31:0]
//   cfg_ch   in   valid/ready (=1)   index[1:0], data[15:0]
//
// Front end handles one request at a time (ring read, sum update, queue push) and
// accepts no new one until its queue push is done. Scaler steps through idle, multiply
// and done, with a 28-step bit-serial divide inside the span that sets the sustained rate.
// Synchronous active-low reset; the sample ring needs no clearing pass.
// A stalled out_ch backs up the scaler, then the 2-entry queue, then in_ch.
module moving_average_range_scaler_core (
  input  logic       clk,
  input  logic       rst_n,
  msa_in_if.sink     in_ch,
  msa_out_if.source  out_ch,
  msa_cfg_if.sink    cfg_ch
);

  msa_pkg::cfg_t    cfg_r;
  msa_pkg::q_stat_t q_stat;
  msa_pkg::item_t   push_item;
  msa_pkg::item_t   pop_item;
  logic             push;
  logic             pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.span_low   <= msa_pkg::SPAN_LOW_RST;
      cfg_r.span_high  <= msa_pkg::SPAN_HIGH_RST;
      cfg_r.full_range <= msa_pkg::FULL_RANGE_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        msa_pkg::REG_SPAN_LOW:   cfg_r.span_low   <= msa_pkg::SPAN_BITS'(cfg_ch.data);
        msa_pkg::REG_SPAN_HIGH:  cfg_r.span_high  <= msa_pkg::SPAN_BITS'(cfg_ch.data);
        msa_pkg::REG_FULL_RANGE: cfg_r.full_range <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  msa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_item(push_item)
  );

  msa_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .pop_item (pop_item),
    .stat     (q_stat)
  );

  msa_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_stat  (q_stat),
    .pop     (pop),
    .pop_item(pop_item),
    .out_ch  (out_ch)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("request pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty))
    else $error("request popped from empty queue");

  a_reset_out_idle: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

endmodule
